@@ rtl/core/fts_pkg.sv @@
// Shared constants, widths and helper functions for the field-oriented-control transform core.
package fts_pkg;

   localparam int AngleWidth  = 16;
   localparam int DataWidth   = 16;
   localparam int CountWidth  = 16;
   localparam int SectorWidth = 3;

   localparam logic [CountWidth-1:0] PeriodReset = 16'd4096;

   localparam logic signed [17:0] SinB      = 18'sd20861;
   localparam logic signed [17:0] SinC      = 18'sd6640;
   localparam logic signed [17:0] SinP      = 18'sd3686;
   localparam logic signed [18:0] InvSqrt3  = 19'sd37837;
   localparam logic signed [18:0] Sqrt3Half = 19'sd56756;
   localparam logic signed [17:0] PiQ12     = 18'sd12868;
   localparam logic signed [17:0] TwoPiQ12  = 18'sd25736;
   localparam logic signed [17:0] HalfPiQ12 = 18'sd6434;

   localparam logic [SectorWidth-1:0] Sector1 = 3'd1;
   localparam logic [SectorWidth-1:0] Sector2 = 3'd2;
   localparam logic [SectorWidth-1:0] Sector3 = 3'd3;
   localparam logic [SectorWidth-1:0] Sector4 = 3'd4;
   localparam logic [SectorWidth-1:0] Sector5 = 3'd5;
   localparam logic [SectorWidth-1:0] Sector6 = 3'd6;

   // Round a 64-bit value by 2^n, half away from zero.
   function automatic logic signed [63:0] rnd64(input logic signed [63:0] v, input int n);
      logic [63:0] m;
      m = v[63] ? (64'd0 - v) : v;
      m = (m + (64'd1 << (n - 1))) >> n;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [DataWidth-1:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) return 16'sh7fff;
      if (v < -64'sd32768) return 16'sh8000;
      return v[DataWidth-1:0];
   endfunction

endpackage

@@ rtl/core/fts_sine.sv @@
// Four-stage pipelined parabolic sine with one refinement step.
module fts_sine (
   input  logic                    clock,
   input  logic                    enable,
   input  logic signed [17:0]      angle,
   output logic signed [17:0]      sine
);
   import fts_pkg::*;

   logic signed [17:0] mag;
   logic signed [31:0] pb_ff, pb_in, a2_ff, a2_in;
   logic signed [47:0] raw;
   logic signed [17:0] s_ff, s_in, s2_ff, t_ff, t_in, sine_ff, sine_in;
   logic signed [35:0] ss;
   logic signed [31:0] pt;

   always_comb begin
      mag     = angle[17] ? -angle : angle;
      pb_in   = 32'(SinB) * 32'(angle);
      a2_in   = 32'(angle) * 32'(mag);
      raw     = (48'(pb_ff) <<< 12) - 48'(SinC) * 48'(a2_ff);
      s_in    = 18'(rnd64(64'(raw), 24));
      ss      = 36'(s_ff) * 36'(s_ff[17] ? -s_ff : s_ff);
      t_in    = 18'(rnd64(64'(ss), 14)) - s_ff;
      pt      = 32'(SinP) * 32'(t_ff);
      sine_in = s2_ff + 18'(rnd64(64'(pt), 14));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pb_ff   <= pb_in;
         a2_ff   <= a2_in;
         s_ff    <= s_in;
         s2_ff   <= s_ff;
         t_ff    <= t_in;
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

@@ rtl/core/foc_transform_svpwm_core.sv @@
// Top level of the transform core: angle wrap, sine, Clarke/Park and space vector compare counts.
//  channel | ports              | handshake
//  request | req_*              | start and busy
//  result  | rsp_*              | rsp_strobe, one cycle
//  csr     | csr_*              | csr_valid and csr_ready
// One word enters every cycle; it passes the angle registers, the sine pipeline, the Park, sector,
// period product and output registers, and rsp_strobe rises on the edge that loads the outputs.
// Busy is always low; results cannot be held off, so the pipeline never stalls.
// Reset clears the valid bits and loads the period with 4096.
module foc_transform_svpwm_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [15:0]            req_rotor_angle,
   input  logic signed [15:0]            req_phase_a_current,
   input  logic signed [15:0]            req_phase_b_current,
   input  logic signed [15:0]            req_volt_d_demand,
   input  logic signed [15:0]            req_volt_q_demand,
   output logic                          rsp_strobe,
   output logic signed [15:0]            rsp_current_d,
   output logic signed [15:0]            rsp_current_q,
   output logic [15:0]                   rsp_duty_one,
   output logic [15:0]                   rsp_duty_two,
   output logic [15:0]                   rsp_duty_three,
   output logic [2:0]                    rsp_sector,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [15:0]                   csr_wdata
);
   import fts_pkg::*;

   localparam int Lat = 9;

   logic [CountWidth-1:0]        period_ff;
   logic [Lat-1:0]               vld_ff;
   logic signed [17:0]           sang_ff, cang_ff;
   logic signed [DataWidth-1:0]  ia_ff [5], ib_ff [4], vd_ff [5], vq_ff [5];
   logic signed [17:0]           sn, cs;
   logic signed [17:0]           a0, a1, c0;
   logic signed [17:0]           ib_sum;
   logic signed [35:0]           ib_prod;
   logic signed [17:0]           ibeta_ff, ibeta_in;
   logic signed [33:0]           id_ff, iq_ff, id_in, iq_in;
   logic signed [33:0]           pva, pvb;
   logic signed [17:0]           va_ff, vb_ff, va_in, vb_in;
   logic signed [35:0]           va_k, v1, v2, v3, t1_in, t2_in;
   logic [33:0]                  t1_ff, t2_ff;
   logic [49:0]                  t1p_ff, t2p_ff;
   logic [2:0]                   sec_in, sec_ff, sec2_ff, sec3_ff;
   logic signed [33:0]           sid_ff, siq_ff, sid2_ff, siq2_ff;
   logic signed [63:0]           t1x, t2x, base, tc, tb, ta;
   logic [15:0]                  d1, d2, d3;

   function automatic logic [15:0] clampc(input logic signed [63:0] v,
                                          input logic [15:0] p);
      if (v < 0) return 16'd0;
      if (v > $signed({48'd0, p})) return p;
      return v[15:0];
   endfunction

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PeriodReset;
         vld_ff    <= '0;
      end else begin
         if (csr_valid) period_ff <= csr_wdata;
         vld_ff <= {vld_ff[Lat-2:0], start};
      end
   end

   always_comb begin
      a0 = 18'(req_rotor_angle);
      if (a0 < -PiQ12) a1 = a0 + TwoPiQ12;
      else if (a0 > PiQ12) a1 = a0 - TwoPiQ12;
      else a1 = a0;
      c0 = a1 + HalfPiQ12;
      if (c0 > PiQ12) c0 = c0 - TwoPiQ12;
   end

   always_ff @(posedge clock) begin
      sang_ff  <= a1;
      cang_ff  <= c0;
      ia_ff[0] <= req_phase_a_current;
      ib_ff[0] <= req_phase_b_current;
      vd_ff[0] <= req_volt_d_demand;
      vq_ff[0] <= req_volt_q_demand;
      for (int i = 1; i < 5; i++) begin
         ia_ff[i] <= ia_ff[i-1];
         vd_ff[i] <= vd_ff[i-1];
         vq_ff[i] <= vq_ff[i-1];
      end
      for (int i = 1; i < 4; i++) begin
         ib_ff[i] <= ib_ff[i-1];
      end
   end

   fts_sine u_sin (.clock(clock), .enable(1'b1), .angle(sang_ff), .sine(sn));
   fts_sine u_cos (.clock(clock), .enable(1'b1), .angle(cang_ff), .sine(cs));

   always_comb begin
      ib_sum   = 18'(ia_ff[3]) + (18'(ib_ff[3]) <<< 1);
      ib_prod  = 36'(ib_sum) * 36'(InvSqrt3);
      ibeta_in = 18'(rnd64(64'(ib_prod), 16));
   end

   always_ff @(posedge clock) begin
      ibeta_ff <= ibeta_in;
   end

   always_comb begin
      id_in = 34'(ia_ff[4]) * 34'(cs) + 34'(ibeta_ff) * 34'(sn);
      iq_in = 34'(ibeta_ff) * 34'(cs) - 34'(ia_ff[4]) * 34'(sn);
      pva   = 34'(vd_ff[4]) * 34'(cs) - 34'(vq_ff[4]) * 34'(sn);
      pvb   = 34'(vd_ff[4]) * 34'(sn) + 34'(vq_ff[4]) * 34'(cs);
      va_in = 18'(rnd64(64'(pva), 14));
      vb_in = 18'(rnd64(64'(pvb), 14));
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      iq_ff <= iq_in;
      va_ff <= va_in;
      vb_ff <= vb_in;
   end

   always_comb begin
      va_k = 36'(Sqrt3Half) * 36'(va_ff);
      v1 = 36'(vb_ff) <<< 16;
      v2 = va_k - (36'(vb_ff) <<< 15);
      v3 = -va_k - (36'(vb_ff) <<< 15);
      if (v1 >= 0) begin
         if (v2 >= 0) begin sec_in = Sector3; t1_in = v2; t2_in = v1; end
         else if (v3 >= 0) begin sec_in = Sector5; t1_in = v1; t2_in = v3; end
         else begin sec_in = Sector1; t1_in = -v2; t2_in = -v3; end
      end else begin
         if (v2 >= 0) begin
            if (v3 >= 0) begin sec_in = Sector6; t1_in = v3; t2_in = v2; end
            else begin sec_in = Sector2; t1_in = -v3; t2_in = -v1; end
         end else begin sec_in = Sector4; t1_in = -v1; t2_in = -v2; end
      end
   end

   always_ff @(posedge clock) begin
      t1_ff  <= t1_in[33:0];
      t2_ff  <= t2_in[33:0];
      sec_ff <= sec_in;
      sid_ff <= id_ff;
      siq_ff <= iq_ff;
   end

   always_ff @(posedge clock) begin
      t1p_ff  <= 50'(t1_ff) * 50'(period_ff);
      t2p_ff  <= 50'(t2_ff) * 50'(period_ff);
      sec2_ff <= sec_ff;
      sid2_ff <= sid_ff;
      siq2_ff <= siq_ff;
   end

   always_comb begin
      t1x  = 64'(t1p_ff);
      t2x  = 64'(t2p_ff);
      base = (64'(period_ff) <<< 30) - t1x - t2x;
      tc   = rnd64(base, 31);
      tb   = rnd64(base + (t1x <<< 1), 31);
      ta   = rnd64(base + (t1x <<< 1) + (t2x <<< 1), 31);
      case (sec2_ff)
         Sector3: begin d1 = clampc(ta, period_ff); d2 = clampc(tb, period_ff);
                        d3 = clampc(tc, period_ff); end
         Sector5: begin d1 = clampc(tc, period_ff); d2 = clampc(ta, period_ff);
                        d3 = clampc(tb, period_ff); end
         Sector1: begin d1 = clampc(tb, period_ff); d2 = clampc(ta, period_ff);
                        d3 = clampc(tc, period_ff); end
         Sector6: begin d1 = clampc(tb, period_ff); d2 = clampc(tc, period_ff);
                        d3 = clampc(ta, period_ff); end
         Sector2: begin d1 = clampc(ta, period_ff); d2 = clampc(tc, period_ff);
                        d3 = clampc(tb, period_ff); end
         default: begin d1 = clampc(tc, period_ff); d2 = clampc(tb, period_ff);
                        d3 = clampc(ta, period_ff); end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_duty_one   <= d1;
      rsp_duty_two   <= d2;
      rsp_duty_three <= d3;
      sec3_ff        <= sec2_ff;
      rsp_current_d  <= sat16(rnd64(64'(sid2_ff), 14));
      rsp_current_q  <= sat16(rnd64(64'(siq2_ff), 14));
   end

   assign rsp_sector = sec3_ff;
   assign rsp_strobe = vld_ff[Lat-1];

`ifndef ASSERT_OFF
   a_sec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_sector >= Sector1 && rsp_sector <= Sector6)) else $error("bad sector");
   a_duty_max: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $stable(period_ff) |-> rsp_duty_one <= period_ff) else $error("duty over");
   a_never_busy: assert property (@(posedge clock) !busy) else $error("busy");
`endif

endmodule
